// ===== sv/mle_pkg.sv =====
// Shared types, mood codes, constant tables and helper functions for the LED animation engine.
`timescale 1ns / 1ps

package mle_pkg;

	localparam int unsigned PIX_IDX_W  = 6;
	localparam int unsigned SCAN_POS_W = 7;
	localparam int unsigned TICK_W     = 32;
	localparam int unsigned SEED_W     = 16;

	localparam logic [7:0] MOOD_OFF    = 8'h30;
	localparam logic [7:0] MOOD_CALM   = 8'h31;
	localparam logic [7:0] MOOD_HAPPY  = 8'h32;
	localparam logic [7:0] MOOD_TENSE  = 8'h33;
	localparam logic [7:0] MOOD_THINK  = 8'h34;
	localparam logic [7:0] MOOD_SPEAK  = 8'h35;
	localparam logic [7:0] MOOD_LISTEN = 8'h36;
	localparam logic [7:0] MOOD_CUSTOM = 8'h3F;

	localparam logic [15:0] LFSR_TAPS = 16'hB400;
	localparam logic [23:0] COLOUR_WHITE = 24'hFF_FFFF;

	// breathing channels: one phase accumulator each
	localparam int unsigned BR_N      = 4;
	localparam int unsigned BR_CALM   = 0;
	localparam int unsigned BR_HAPPY  = 1;
	localparam int unsigned BR_THINK  = 2;
	localparam int unsigned BR_LISTEN = 3;

	localparam logic [8:0] BR_PERIOD [BR_N] = '{9'd200, 9'd75, 9'd300, 9'd60};
	localparam logic [7:0] BR_QSTEP [BR_N] = '{8'(255 / 200), 8'(255 / 75),
		8'(255 / 300), 8'(255 / 60)};
	localparam logic [8:0] BR_RSTEP [BR_N] = '{9'(255 % 200), 9'(255 % 75),
		9'(255 % 300), 9'(255 % 60)};

	typedef struct packed {
		logic [BR_N-1:0][7:0]    breath;
		logic [SCAN_POS_W-1:0]   scan_pos;
	} phase_t;

	localparam logic [7:0] QUARTER_ROM [65] = '{
		8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149, 8'd152, 8'd155,
		8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173, 8'd176, 8'd179, 8'd182, 8'd184,
		8'd187, 8'd190, 8'd193, 8'd195, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210,
		8'd213, 8'd215, 8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
		8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246,
		8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253, 8'd254,
		8'd254, 8'd254, 8'd254, 8'd254, 8'd255
	};

	function automatic logic [7:0] sine_rom(input logic [7:0] t);
		logic [6:0] k;
		logic [7:0] v;
		k = t[6:0];
		if (k > 7'd64)
			k = 7'(8'd128 - {1'b0, k});
		v = QUARTER_ROM[k];
		if (!t[7] || k == 7'd0)
			return v;
		if (v == 8'd255)
			return 8'd0;
		return 8'd254 - v;
	endfunction

	// floor(x / 255), exact over the range of products of two 8-bit values
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return s[15:8];
	endfunction

	function automatic logic [7:0] scale(input logic [7:0] v, input logic [7:0] b);
		logic [15:0] x;
		x = 16'(v) * 16'(b);
		return div255(x);
	endfunction

	function automatic logic [15:0] lfsr_step(input logic [15:0] s);
		logic [15:0] n;
		n = s >> 1;
		if (s[0])
			n = n ^ LFSR_TAPS;
		return n;
	endfunction

	function automatic logic mood_known(input logic [7:0] code);
		unique case (code) inside
			MOOD_OFF, MOOD_CALM, MOOD_HAPPY, MOOD_TENSE,
			MOOD_THINK, MOOD_SPEAK, MOOD_LISTEN, MOOD_CUSTOM: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

endpackage

// ===== sv/mle_timebase.sv =====
// Tick counter with incremental breathing phases and scanner position.
`timescale 1ns / 1ps

module mle_timebase
	import mle_pkg::*;
#(
	parameter int unsigned NUM_LEDS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   clear,
	input  logic   advance,
	output phase_t phase
);

	localparam logic [SCAN_POS_W-1:0] SCAN_LAST = SCAN_POS_W'(2 * NUM_LEDS - 1);

	logic [TICK_W-1:0]     tick_q;
	logic [TICK_W-1:0]     tick_d;
	logic [SCAN_POS_W-1:0] pos_q;
	logic [SCAN_POS_W-1:0] pos_d;
	logic [8:0]            rem_q [BR_N];
	logic [8:0]            rem_d [BR_N];
	logic [8:0]            rr_q  [BR_N];
	logic [8:0]            rr_d  [BR_N];
	logic [7:0]            quo_q [BR_N];
	logic [7:0]            quo_d [BR_N];
	logic [9:0]            rr_sum [BR_N];
	logic                  wrap;

	// a wrap of the 32-bit counter lands every residue back on zero
	assign wrap = (tick_q == '1);

	always_comb begin
		tick_d = tick_q;
		pos_d  = pos_q;
		if (clear) begin
			tick_d = '0;
			pos_d  = '0;
		end else if (advance) begin
			tick_d = tick_q + TICK_W'(1);
			pos_d  = (wrap || pos_q == SCAN_LAST) ? '0 : pos_q + SCAN_POS_W'(1);
		end
		for (int k = 0; k < BR_N; k++) begin
			rem_d[k]  = rem_q[k];
			rr_d[k]   = rr_q[k];
			quo_d[k]  = quo_q[k];
			rr_sum[k] = {1'b0, rr_q[k]} + {1'b0, BR_RSTEP[k]};
			if (clear || (advance && (wrap || rem_q[k] == BR_PERIOD[k] - 9'd1))) begin
				rem_d[k] = '0;
				rr_d[k]  = '0;
				quo_d[k] = '0;
			end else if (advance) begin
				rem_d[k] = rem_q[k] + 9'd1;
				if (rr_sum[k] >= {1'b0, BR_PERIOD[k]}) begin
					rr_d[k]  = 9'(rr_sum[k] - {1'b0, BR_PERIOD[k]});
					quo_d[k] = quo_q[k] + BR_QSTEP[k] + 8'd1;
				end else begin
					rr_d[k]  = rr_sum[k][8:0];
					quo_d[k] = quo_q[k] + BR_QSTEP[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			pos_q  <= '0;
			for (int k = 0; k < BR_N; k++) begin
				rem_q[k] <= '0;
				rr_q[k]  <= '0;
				quo_q[k] <= '0;
			end
		end else begin
			tick_q <= tick_d;
			pos_q  <= pos_d;
			for (int k = 0; k < BR_N; k++) begin
				rem_q[k] <= rem_d[k];
				rr_q[k]  <= rr_d[k];
				quo_q[k] <= quo_d[k];
			end
		end
	end

	always_comb begin
		phase.scan_pos = pos_q;
		for (int k = 0; k < BR_N; k++)
			phase.breath[k] = quo_q[k];
	end

endmodule

// ===== sv/mle_shade.sv =====
// Per-pixel colour logic for every mood.
`timescale 1ns / 1ps

module mle_shade
	import mle_pkg::*;
#(
	parameter int unsigned NUM_LEDS = 16
) (
	input  logic [7:0]           mood,
	input  phase_t               phase,
	input  logic [PIX_IDX_W-1:0] pix,
	input  logic [23:0]          saved_colour,
	input  logic [15:0]          lfsr_next,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue
);

	localparam logic [SCAN_POS_W-1:0] N_LEDS    = SCAN_POS_W'(NUM_LEDS);
	localparam logic [SCAN_POS_W-1:0] SCAN_LAST = SCAN_POS_W'(2 * NUM_LEDS - 1);

	logic [7:0]            ph;
	logic [7:0]            sine;
	logic [7:0]            br;
	logic [15:0]           flick;
	logic [SCAN_POS_W-1:0] head;
	logic [SCAN_POS_W-1:0] pix_w;
	logic [SCAN_POS_W-1:0] pix_gap;

	always_comb begin
		case (mood)
			MOOD_HAPPY:  ph = phase.breath[BR_HAPPY];
			MOOD_THINK:  ph = phase.breath[BR_THINK];
			MOOD_LISTEN: ph = phase.breath[BR_LISTEN];
			default:     ph = phase.breath[BR_CALM];
		endcase
		sine = sine_rom(ph);
		case (mood)
			MOOD_HAPPY:  br = {1'b0, sine[7:1]} + 8'd80;
			MOOD_THINK:  br = {2'b0, sine[7:2]} + 8'd30;
			MOOD_LISTEN: br = {1'b0, sine[7:1]} + 8'd30;
			default:     br = {1'b0, sine[7:1]} + 8'd20;
		endcase
	end

	// bounce: head runs up the strip and back down
	assign head    = (phase.scan_pos < N_LEDS) ? phase.scan_pos : SCAN_LAST - phase.scan_pos;
	assign pix_w   = {1'b0, pix};
	assign pix_gap = (pix_w >= head) ? pix_w - head : head - pix_w;
	assign flick   = 16'(lfsr_next[7:0]) * 16'd195;

	always_comb begin
		red   = '0;
		green = '0;
		blue  = '0;
		case (mood)
			MOOD_CALM: begin
				red   = scale(8'd255, br);
				green = scale(8'd115, br);
			end
			MOOD_HAPPY: begin
				red   = scale(8'd255, br);
				green = scale(8'd160, br);
			end
			MOOD_THINK: begin
				red  = scale(8'd160, br);
				blue = scale(8'd255, br);
			end
			MOOD_LISTEN: begin
				green = scale(8'd220, br);
				blue  = scale(8'd60, br);
			end
			MOOD_CUSTOM: begin
				red   = saved_colour[23:16];
				green = saved_colour[15:8];
				blue  = saved_colour[7:0];
			end
			MOOD_TENSE: begin
				red = flick[15:8] + 8'd60;
			end
			MOOD_SPEAK: begin
				if (pix_gap == SCAN_POS_W'(0)) begin
					green = 8'd220;
					blue  = 8'd255;
				end else if (pix_gap == SCAN_POS_W'(1)) begin
					green = 8'd60;
					blue  = 8'd80;
				end else if (pix_gap == SCAN_POS_W'(2)) begin
					green = 8'd15;
					blue  = 8'd20;
				end
			end
			default: begin
				red = '0;
			end
		endcase
	end

endmodule

// ===== sv/mood_led_animation_engine.sv =====
// Top level of the mood LED animation engine: item stage, mood state and pixel output register.
`timescale 1ns / 1ps
// The first pixel of a tick passes the item stage and is loaded into the output register when it is
// empty or its pixel leaves. A known-mood tick gives NUM_LEDS pixels, one pixel per cycle while the
// output can load, set by the single pixel shader behind the item stage; commands and unknown-mood
// ticks give none. The next item is taken in the cycle that the last pixel of a frame is loaded.
// Reset: asynchronous, clears mood to calm, tick count to zero, colour to white, LFSR to 1.

module mood_led_animation_engine
	import mle_pkg::*;
#(
	parameter int unsigned NUM_LEDS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  mood_code,
	input  logic        force_restart,
	input  logic        has_color,
	input  logic [7:0]  custom_red,
	input  logic [7:0]  custom_green,
	input  logic [7:0]  custom_blue,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] random_seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  white,
	output logic        last_pixel
);

	localparam int unsigned PIX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(NUM_LEDS - 1);

	// item stage
	logic             v_s1;
	logic             op_s1;
	logic [7:0]       code_s1;
	logic             force_s1;
	logic             hasc_s1;
	logic [23:0]      colour_s1;
	logic [PIX_W-1:0] pix_s1;

	// mood state
	logic [7:0]       mood_q;
	logic [23:0]      saved_colour_q;
	logic [15:0]      lfsr_q;
	logic [15:0]      lfsr_next;

	// output register
	logic             out_valid_q;
	logic [5:0]       pixel_index_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [7:0]       blue_q;
	logic             last_q;

	logic             in_xfer;
	logic             known;
	logic             tick_emit;
	logic             out_load;
	logic             pix_last;
	logic             done_s1;
	logic             advance;
	logic             clear;
	phase_t           phase;
	logic [7:0]       shade_r;
	logic [7:0]       shade_g;
	logic [7:0]       shade_b;

	assign known     = mood_known(mood_q);
	assign tick_emit = v_s1 && !op_s1 && known;
	// load the output register when it is empty or its pixel leaves this cycle
	assign out_load  = tick_emit && (!out_valid_q || out_ready);
	assign pix_last  = (pix_s1 == PIX_LAST);
	// commands and unknown-mood ticks drain as soon as they sit in the stage; a frame at its last pixel load
	assign done_s1   = v_s1 && (op_s1 || !known || (out_load && pix_last));
	assign in_ready  = !v_s1 || done_s1;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// the counter advances once the last pixel of a frame is loaded, or at once for an unknown mood
	assign advance = v_s1 && !op_s1 && (!known || (out_load && pix_last));
	// a command restarts the counter when forced or when the mood changes
	assign clear   = v_s1 && op_s1 && (force_s1 || code_s1 != mood_q);

	assign lfsr_next = lfsr_step(lfsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			pix_s1 <= '0;
		end else if (in_xfer) begin
			v_s1   <= 1'b1;
			pix_s1 <= '0;
		end else if (done_s1) begin
			v_s1 <= 1'b0;
		end else if (out_load) begin
			pix_s1 <= pix_s1 + PIX_W'(1);
		end
	end

	// hold the item's payload for as long as it sits in the stage
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1     <= op;
			code_s1   <= mood_code;
			force_s1  <= force_restart;
			hasc_s1   <= has_color;
			colour_s1 <= {custom_red, custom_green, custom_blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mood_q         <= MOOD_CALM;
			saved_colour_q <= COLOUR_WHITE;
		end else if (v_s1 && op_s1) begin
			mood_q <= code_s1;
			if (code_s1 == MOOD_CUSTOM && hasc_s1)
				saved_colour_q <= colour_s1;
		end
	end

	// a zero seed would lock the LFSR, so load 1 instead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			lfsr_q <= (random_seed == '0) ? 16'd1 : random_seed;
		end else if (out_load && mood_q == MOOD_TENSE) begin
			lfsr_q <= lfsr_next;
		end
	end

	mle_timebase #(
		.NUM_LEDS(NUM_LEDS)
	) u_timebase (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (clear),
		.advance(advance),
		.phase  (phase)
	);

	mle_shade #(
		.NUM_LEDS(NUM_LEDS)
	) u_shade (
		.mood        (mood_q),
		.phase       (phase),
		.pix         (PIX_IDX_W'(pix_s1)),
		.saved_colour(saved_colour_q),
		.lfsr_next   (lfsr_next),
		.red         (shade_r),
		.green       (shade_g),
		.blue        (shade_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_index_q <= PIX_IDX_W'(pix_s1);
			red_q         <= shade_r;
			green_q       <= shade_g;
			blue_q        <= shade_b;
			last_q        <= pix_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign white       = 8'd0;
	assign last_pixel  = last_q;

`ifndef SYNTHESIS
	// the frame marker sits on the final pixel only
	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_pixel == (pixel_index == PIX_IDX_W'(NUM_LEDS - 1))))
		else $error("last_pixel out of step with pixel_index");

	// within a frame the pixels follow one another without a gap
	a_frame_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=>
			out_valid && pixel_index == $past(pixel_index) + 6'd1)
		else $error("frame broken after a pixel transfer");

	// no new item enters while a frame is part way out
	a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		tick_emit && !pix_last |-> !in_ready)
		else $error("item taken in the middle of a frame");

	// the flicker generator never reaches the all-zero state
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0)
		else $error("flicker LFSR locked at zero");
`endif

endmodule
